// ----- rtl/core/gdc_pkg.sv -----
// Shared types, constants and helper functions for the distortion chain core.
// No dependencies; gdc_mul, gdc_div and the core top level import this package.
`default_nettype none

package gdc_pkg;

	// configuration port
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_PRE_GAIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HPF_WCT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LPF_WCT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LPF_DAMP = 3'd3;

	// shared multiplier and divider widths
	localparam int MUL_A_W = 34;
	localparam int MUL_B_W = 32;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int DIV_N_W = 64;
	localparam int DIV_D_W = 32;

	// clipper and exponential constants
	localparam int CLIP_Q_OFS = 26843546;
	localparam int CLIP_NEAR  = 1342;
	localparam int CLIP_LIMIT = 16777216;
	localparam int CLIP_BIAS  = -33634167;
	localparam int EXP_K      = 193635251;
	localparam int LN2_Q30    = 744261118;
	localparam int Q30_ONE    = 1 << 30;

	localparam int PROTO_TAPS = 69;
	localparam int PROTO_HALF = 35;

	localparam logic signed [15:0] PROTO_COEF [PROTO_HALF] = '{
		-16'sd7, -16'sd18, -16'sd35, -16'sd54, -16'sd66, -16'sd61, -16'sd29,
		16'sd33, 16'sd118, 16'sd206, 16'sd268, 16'sd274, 16'sd206, 16'sd69,
		-16'sd107, -16'sd264, -16'sd340, -16'sd288, -16'sd100, 16'sd182,
		16'sd467, 16'sd639, 16'sd601, 16'sd310, -16'sd188, -16'sd751,
		-16'sd1175, -16'sd1243, -16'sd796, 16'sd209, 16'sd1664, 16'sd3325,
		16'sd4864, 16'sd5951, 16'sd6343
	};

	// 2^(-2^-i), i = 1..8, in Q.30
	localparam logic [29:0] POW2_FRAC [8] = '{
		30'd759250125, 30'd902905651, 30'd984625594, 30'd1028218693,
		30'd1050733751, 30'd1062175491, 30'd1067942999, 30'd1070838486
	};

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_FIR,
		ST_FIRQ,
		ST_HPN,
		ST_HPD,
		ST_PG,
		ST_PGR,
		ST_EXP_S,
		ST_EXP_F,
		ST_EXP_ML,
		ST_EXP_MW,
		ST_EXP_Y,
		ST_EXP_YW,
		ST_EXP_YY,
		ST_EXP_P,
		ST_EXP_MP,
		ST_EXP_E,
		ST_CLIP_VE,
		ST_CLIP_DS,
		ST_CLIP_DW,
		ST_CLIP_F,
		ST_LPF_W,
		ST_LPF_D,
		ST_LPF_A,
		ST_LPF_N1,
		ST_LPF_N2,
		ST_LPF_N3,
		ST_LPF_DW,
		ST_OUT
	} state_t;

	// symmetric prototype coefficient; taps past the prototype weigh zero
	function automatic logic signed [15:0] tap_coef(input logic [6:0] n);
		logic [6:0] m;
		m = (n < 7'(PROTO_HALF)) ? n : 7'(PROTO_TAPS - 1) - n;
		if (n >= 7'(PROTO_TAPS))
			return 16'sd0;
		return PROTO_COEF[m[5:0]];
	endfunction

	// clamp a wide signed value to the 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [MUL_P_W-1:0] v);
		if (v > MUL_P_W'(64'sh7fffffff))
			return 32'sh7fffffff;
		if (v < -MUL_P_W'(64'sh80000000))
			return 32'sh80000000;
		return v[31:0];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/gdc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gdc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 69
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port, then registered read port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/core/gdc_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on gdc_pkg for operand widths.
`default_nettype none

module gdc_mul (
	input  logic                               clk,
	input  logic signed [gdc_pkg::MUL_A_W-1:0] a,
	input  logic signed [gdc_pkg::MUL_B_W-1:0] b,
	output logic signed [gdc_pkg::MUL_P_W-1:0] p
);
	import gdc_pkg::*;

	// register the product for use in the following cycle
	always_ff @(posedge clk) begin
		p <= MUL_P_W'(a) * MUL_P_W'(b);
	end

endmodule

`default_nettype wire

// ----- rtl/core/gdc_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on gdc_pkg for operand widths.
`default_nettype none

module gdc_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [gdc_pkg::DIV_N_W-1:0] dividend,
	input  logic [gdc_pkg::DIV_D_W-1:0] divisor,
	output logic                        done,
	output logic [gdc_pkg::DIV_N_W-1:0] quotient
);
	import gdc_pkg::*;

	localparam int CW = $clog2(DIV_N_W + 1);

	logic [DIV_D_W-1:0] rem_q;
	logic [DIV_D_W-1:0] dvs_q;
	logic [DIV_N_W-1:0] quo_q;
	logic [CW-1:0]      cnt_q;
	logic               done_q;
	logic [DIV_D_W+1:0] trial;
	logic               ge;

	// trial subtract of the shifted remainder
	always_comb begin
		trial = {1'b0, rem_q, quo_q[DIV_N_W-1]} - {2'b00, dvs_q};
		ge    = !trial[DIV_D_W+1];
	end

	// step counter and completion flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && (cnt_q == CW'(1));
			if (start)
				cnt_q <= CW'(DIV_N_W);
			else if (cnt_q != '0)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	// shift remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? trial[DIV_D_W-1:0] : {rem_q[DIV_D_W-2:0], quo_q[DIV_N_W-1]};
			quo_q <= {quo_q[DIV_N_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ----- rtl/core/guitar_distortion_chain_core.sv -----
// Top level of the distortion chain: sequencer, state registers and datapath.
// Depends on gdc_pkg, gdc_ram, gdc_mul and gdc_div.
//
//   channel   signals                          direction
//   input     in_valid, in_ready, sample_in    transfer in
//   output    out_valid, out_ready, sample_out transfer out
//   config    cfg_we, cfg_index, cfg_data      write only
//
// A new sample is taken only when the sequencer is idle. Each sample walks the FIR
// taps through the delay-line RAM, then takes three divides on the shared divider,
// with one shared multiplier for all products. Samples above the clipper knee skip
// the multiply before the clipper divide; samples near the knee skip the
// exponential and one divide.
// Reset clears all filter history at once; delay-line entries carry valid bits.
// A finished result waits in the output register while the next sample enters.
`default_nettype none

module guitar_distortion_chain_core #(
	parameter int FIR_TAPS    = 69,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [gdc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gdc_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] sample_out
);
	import gdc_pkg::*;

	localparam int AW     = (FIR_TAPS > 1) ? $clog2(FIR_TAPS) : 1;
	localparam int KW     = $clog2(FIR_TAPS + 2);
	localparam int SCL_SH = 28 - SAMPLE_BITS;
	localparam logic [KW-1:0] K_END = KW'(FIR_TAPS + 1);
	localparam logic signed [33:0] OUT_MAX = (34'sd1 <<< (SAMPLE_BITS - 1)) - 34'sd1;
	localparam logic signed [33:0] OUT_RND = 34'sd1 <<< (SCL_SH - 1);
	localparam logic signed [33:0] FS_POS  = 34'sd134217728;

	state_t state_q, state_d;

	// config
	logic [23:0] pre_gain_q;
	logic [17:0] hpf_wct_q;
	logic [17:0] lpf_wct_q;
	logic [16:0] lpf_damp_q;

	// delay line control
	logic [AW-1:0]       wp_q, rd_addr_q;
	logic [FIR_TAPS-1:0] fir_vld_q;
	logic [KW-1:0]       k_q, tap_s1;
	logic                rd_go, rd_v_s1, mul_v_s2, vld_s1;
	logic [SAMPLE_BITS-1:0] ram_rdata;
	logic                accept;

	// filter history
	logic signed [31:0] hpf_xp_q, hpf_yp_q;
	logic signed [31:0] lpf_x1_q, lpf_x2_q, lpf_y1_q, lpf_y2_q;

	// work registers
	logic signed [63:0] acc_q, nacc_q;
	logic signed [31:0] fir_q, hpf_q, clip_q;
	logic [31:0]        v_q;
	logic               upos_q, div_neg_q;
	logic [29:0]        frac_q;
	logic [7:0]         ip_q;
	logic [30:0]        m_q, poly_q, e_q;
	logic [21:0]        y_q;
	logic [2:0]         bi_q;
	logic [31:0]        den_q;
	logic [63:0]        term_q;
	logic [20:0]        wc2_q;
	logic signed [31:0] a1_q, a2_q;
	logic [31:0]        a0_q;
	logic signed [SAMPLE_BITS-1:0] res_q, out_q;
	logic               out_valid_q;

	// shared units
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] mul_p;
	logic                      div_start, div_done;
	logic [DIV_N_W-1:0]        div_num, div_q;
	logic [DIV_D_W-1:0]        div_den;

	// combinational datapath terms
	logic signed [MUL_P_W-1:0] fir_sh, hp_num, div_sq, clip_sum;
	logic signed [31:0]        xg, lpf_v;
	logic signed [33:0]        u, lsum, o34, r34;
	logic                      near;
	logic [4:0]                fbit_idx;
	logic [30:0]               mm, e_v;
	logic [19:0]               dw;
	logic signed [63:0]        lnum;
	logic                      load_out;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign rd_go    = (state_q == ST_FIR) && (k_q < KW'(FIR_TAPS));
	assign load_out = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	gdc_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (FIR_TAPS)
	) u_fir_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (wp_q),
		.wdata (sample_in),
		.re    (rd_go),
		.raddr (rd_addr_q),
		.rdata (ram_rdata)
	);

	gdc_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	gdc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_q)
	);

	// datapath terms that feed several states
	always_comb begin
		fir_sh   = ((MUL_P_W'(acc_q) <<< SCL_SH) + MUL_P_W'(16384)) >>> 15;
		hp_num   = ((MUL_P_W'(fir_q) - MUL_P_W'(hpf_xp_q)) <<< 17) + mul_p;
		div_sq   = div_neg_q ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
		xg       = sat32((mul_p + MUL_P_W'(32768)) >>> 16);
		u        = 34'(xg) + 34'(CLIP_Q_OFS);
		near     = (u > -34'(CLIP_NEAR)) && (u < 34'(CLIP_NEAR));
		fbit_idx = 5'd29 - 5'(bi_q);
		mm       = 31'((mul_p + MUL_P_W'(536870912)) >>> 30);
		e_v      = (ip_q >= 8'd31) ? 31'd0 : (mm >> ip_q[4:0]);
		clip_sum = MUL_P_W'(CLIP_BIAS) + $signed({2'b00, term_q});
		dw       = 20'((mul_p + MUL_P_W'(32768)) >>> 16);
		lsum     = 34'(clip_q) + (34'(lpf_x1_q) <<< 1) + 34'(lpf_x2_q);
		lnum     = nacc_q - 64'(mul_p);
		lpf_v    = sat32(div_sq);
		// clamp to full scale, round to the output format, clip the top code
		if (lpf_v > 32'(FS_POS))
			o34 = FS_POS;
		else if (lpf_v < -32'(FS_POS))
			o34 = -FS_POS;
		else
			o34 = 34'(lpf_v);
		r34 = (o34 + OUT_RND) >>> SCL_SH;
		if (r34 > OUT_MAX)
			r34 = OUT_MAX;
	end

	// sequencer: next state and shared unit operands
	always_comb begin
		state_d   = state_q;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = ST_FIR;
			end
			ST_FIR: begin
				if (rd_v_s1 && vld_s1)
					mul_a = MUL_A_W'($signed(ram_rdata));
				mul_b = MUL_B_W'(tap_coef(7'(tap_s1)));
				if (k_q == K_END)
					state_d = ST_FIRQ;
			end
			ST_FIRQ: begin
				mul_a   = MUL_A_W'(hpf_yp_q);
				mul_b   = MUL_B_W'(131072) - MUL_B_W'(hpf_wct_q);
				state_d = ST_HPN;
			end
			ST_HPN: begin
				div_start = 1'b1;
				div_num   = hp_num[MUL_P_W-1] ? 64'(-hp_num) : 64'(hp_num);
				div_den   = 32'd131072 + 32'(hpf_wct_q);
				state_d   = ST_HPD;
			end
			ST_HPD: begin
				if (div_done)
					state_d = ST_PG;
			end
			ST_PG: begin
				mul_a   = MUL_A_W'(hpf_q);
				mul_b   = MUL_B_W'(pre_gain_q);
				state_d = ST_PGR;
			end
			ST_PGR: begin
				state_d = near ? ST_CLIP_F : ST_EXP_S;
			end
			ST_EXP_S: begin
				mul_a   = MUL_A_W'(v_q);
				mul_b   = MUL_B_W'(EXP_K);
				state_d = ST_EXP_F;
			end
			ST_EXP_F: begin
				state_d = ST_EXP_ML;
			end
			ST_EXP_ML: begin
				mul_a   = MUL_A_W'(m_q);
				mul_b   = frac_q[fbit_idx] ? MUL_B_W'(POW2_FRAC[bi_q]) : MUL_B_W'(Q30_ONE);
				state_d = ST_EXP_MW;
			end
			ST_EXP_MW: begin
				state_d = (bi_q == 3'd7) ? ST_EXP_Y : ST_EXP_ML;
			end
			ST_EXP_Y: begin
				mul_a   = MUL_A_W'(frac_q[21:0]);
				mul_b   = MUL_B_W'(LN2_Q30);
				state_d = ST_EXP_YW;
			end
			ST_EXP_YW: begin
				state_d = ST_EXP_YY;
			end
			ST_EXP_YY: begin
				mul_a   = MUL_A_W'(y_q);
				mul_b   = MUL_B_W'(y_q);
				state_d = ST_EXP_P;
			end
			ST_EXP_P: begin
				state_d = ST_EXP_MP;
			end
			ST_EXP_MP: begin
				mul_a   = MUL_A_W'(m_q);
				mul_b   = MUL_B_W'(poly_q);
				state_d = ST_EXP_E;
			end
			ST_EXP_E: begin
				state_d = upos_q ? ST_CLIP_DS : ST_CLIP_VE;
			end
			ST_CLIP_VE: begin
				mul_a   = MUL_A_W'(v_q);
				mul_b   = MUL_B_W'(e_q);
				state_d = ST_CLIP_DS;
			end
			ST_CLIP_DS: begin
				div_start = 1'b1;
				div_num   = upos_q ? {2'b00, v_q, 30'd0} : 64'(mul_p);
				div_den   = den_q;
				state_d   = ST_CLIP_DW;
			end
			ST_CLIP_DW: begin
				if (div_done)
					state_d = ST_CLIP_F;
			end
			ST_CLIP_F: begin
				state_d = ST_LPF_W;
			end
			ST_LPF_W: begin
				mul_a   = MUL_A_W'(lpf_wct_q);
				mul_b   = MUL_B_W'(lpf_wct_q);
				state_d = ST_LPF_D;
			end
			ST_LPF_D: begin
				mul_a   = MUL_A_W'(lpf_damp_q);
				mul_b   = MUL_B_W'(lpf_wct_q);
				state_d = ST_LPF_A;
			end
			ST_LPF_A: begin
				mul_a   = lsum;
				mul_b   = MUL_B_W'(wc2_q);
				state_d = ST_LPF_N1;
			end
			ST_LPF_N1: begin
				mul_a   = MUL_A_W'(lpf_y1_q);
				mul_b   = a1_q;
				state_d = ST_LPF_N2;
			end
			ST_LPF_N2: begin
				mul_a   = MUL_A_W'(lpf_y2_q);
				mul_b   = a2_q;
				state_d = ST_LPF_N3;
			end
			ST_LPF_N3: begin
				div_start = 1'b1;
				div_num   = lnum[63] ? -lnum : lnum;
				div_den   = a0_q;
				state_d   = ST_LPF_DW;
			end
			ST_LPF_DW: begin
				if (div_done)
					state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// config writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_gain_q <= 24'd655360;
			hpf_wct_q  <= 18'd858;
			lpf_wct_q  <= 18'd42893;
			lpf_damp_q <= 17'd46341;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PRE_GAIN: pre_gain_q <= cfg_data;
				CFG_HPF_WCT:  hpf_wct_q  <= cfg_data[17:0];
				CFG_LPF_WCT:  lpf_wct_q  <= cfg_data[17:0];
				CFG_LPF_DAMP: lpf_damp_q <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// delay line pointers, tap pipeline flags, history and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			rd_addr_q   <= '0;
			fir_vld_q   <= '0;
			k_q         <= '0;
			rd_v_s1     <= 1'b0;
			mul_v_s2    <= 1'b0;
			hpf_xp_q    <= '0;
			hpf_yp_q    <= '0;
			lpf_x1_q    <= '0;
			lpf_x2_q    <= '0;
			lpf_y1_q    <= '0;
			lpf_y2_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1  <= rd_go;
			mul_v_s2 <= rd_v_s1;
			if (accept) begin
				fir_vld_q[wp_q] <= 1'b1;
				rd_addr_q       <= wp_q;
				wp_q            <= (wp_q == AW'(FIR_TAPS - 1)) ? '0 : wp_q + AW'(1);
				k_q             <= '0;
			end
			if (state_q == ST_FIR)
				k_q <= k_q + KW'(1);
			// walk back from the newest sample
			if (rd_go)
				rd_addr_q <= (rd_addr_q == '0) ? AW'(FIR_TAPS - 1) : rd_addr_q - AW'(1);
			if (state_q == ST_HPN)
				hpf_xp_q <= fir_q;
			if (state_q == ST_HPD && div_done)
				hpf_yp_q <= sat32(div_sq);
			if (state_q == ST_LPF_DW && div_done) begin
				lpf_x2_q <= lpf_x1_q;
				lpf_x1_q <= clip_q;
				lpf_y2_q <= lpf_y1_q;
				lpf_y1_q <= lpf_v;
			end
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// working registers of the datapath
	always_ff @(posedge clk) begin
		tap_s1 <= k_q;
		vld_s1 <= fir_vld_q[rd_addr_q];
		if (accept)
			acc_q <= '0;
		else if (mul_v_s2)
			acc_q <= acc_q + 64'(mul_p);
		unique case (state_q)
			ST_FIRQ: fir_q <= sat32(fir_sh);
			ST_HPN: div_neg_q <= hp_num[MUL_P_W-1];
			ST_HPD: hpf_q <= sat32(div_sq);
			ST_PGR: begin
				upos_q <= (u > 34'sd0);
				v_q    <= u[33] ? 32'(-u) : 32'(u);
				term_q <= 64'(CLIP_LIMIT);
			end
			ST_EXP_F: begin
				ip_q   <= mul_p[58:51];
				frac_q <= mul_p[50:21];
				m_q    <= 31'(Q30_ONE);
				bi_q   <= '0;
			end
			ST_EXP_MW: begin
				m_q  <= mm;
				bi_q <= bi_q + 3'd1;
			end
			ST_EXP_YW: y_q <= mul_p[51:30];
			ST_EXP_P: poly_q <= 31'(Q30_ONE) - 31'(y_q) + 31'(mul_p[43:31]);
			ST_EXP_E: begin
				e_q   <= e_v;
				den_q <= (e_v == 31'(Q30_ONE)) ? 32'd1 : 32'(Q30_ONE) - 32'(e_v);
			end
			ST_CLIP_DW: term_q <= div_q;
			ST_CLIP_F: clip_q <= sat32(clip_sum);
			ST_LPF_D: wc2_q <= 21'((mul_p + MUL_P_W'(32768)) >>> 16);
			ST_LPF_A: begin
				a1_q <= (32'(wc2_q) - 32'd262144) << 1;
				a2_q <= 32'd262144 - (32'(dw) << 2) + 32'(wc2_q);
				a0_q <= 32'd262144 + (32'(dw) << 2) + 32'(wc2_q);
			end
			ST_LPF_N1: nacc_q <= 64'(mul_p);
			ST_LPF_N2: nacc_q <= nacc_q - 64'(mul_p);
			ST_LPF_N3: div_neg_q <= lnum[63];
			ST_LPF_DW: res_q <= SAMPLE_BITS'(r34);
			default: ;
		endcase
		if (load_out)
			out_q <= res_q;
	end

	assign out_valid  = out_valid_q;
	assign sample_out = out_q;

endmodule

`default_nettype wire

// ----- tb/guitar_distortion_chain_core_test.sv -----
// Self-checking testbench for guitar_distortion_chain_core: per-sample prediction of the
// FIR, high-pass, soft-clipper and resonant low-pass chain, with random flow control.
// Depends on gdc_pkg and the core RTL only.
`timescale 1ns / 100ps

module guitar_distortion_chain_core_test;
	import gdc_pkg::*;

	localparam int TAPS = 69;
	localparam int SBITS = 16;
	localparam int DRAIN_CYCLES = 400;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd5;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_PRE_GAIN;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [SBITS-1:0] sample_in = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [SBITS-1:0] sample_out;

	guitar_distortion_chain_core #(.FIR_TAPS(TAPS), .SAMPLE_BITS(SBITS)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .sample_in(sample_in),
		.out_valid(out_valid), .out_ready(out_ready), .sample_out(sample_out)
	);

	// predictor state and register copies
	longint delay_line [TAPS];
	int unsigned write_ptr;
	longint hp_x_prev, hp_y_prev;
	longint lp_x1, lp_x2, lp_y1, lp_y2;
	longint unsigned gain_reg, hp_w_reg, lp_w_reg, lp_damp_reg;

	logic signed [SBITS-1:0] pending_samples [$];
	logic signed [SBITS-1:0] expected_samples [$];
	int send_gap = 0;
	int stall_left = 0;
	int mismatches = 0;
	int samples_in = 0;
	int samples_out = 0;
	int setting_count = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint clamp_word(longint v);
		return clamp(v, -64'sd2147483648, 64'sd2147483647);
	endfunction

	function automatic longint round_shift(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint fir_weight(int n);
		if (n >= PROTO_TAPS)
			return 0;
		return longint'(PROTO_COEF[n < PROTO_HALF ? n : PROTO_TAPS - 1 - n]);
	endfunction

	// exp(-8 v) in Q.30 via 2^-s: shift, table for top fraction bits, poly for the rest
	function automatic longint unsigned decay_q30(longint unsigned v);
		longint unsigned s, ip, frac, m, y, poly;
		s = (v * 64'(EXP_K)) >> 21;
		ip = s >> 30;
		frac = s & 64'h3FFF_FFFF;
		m = 64'd1 << 30;
		if (ip >= 31)
			return 0;
		for (int i = 0; i < 8; i++)
			if (frac[29-i])
				m = (m * 64'(POW2_FRAC[i]) + (64'd1 << 29)) >> 30;
		y = ((frac & 64'h3F_FFFF) * 64'(LN2_Q30)) >> 30;
		poly = (64'd1 << 30) - y + ((y * y) >> 31);
		m = (m * poly + (64'd1 << 29)) >> 30;
		return m >> ip;
	endfunction

	function automatic longint soft_clip(longint xg);
		longint u, term;
		longint unsigned v, e, den;
		u = xg + longint'(CLIP_Q_OFS);
		if (u > -CLIP_NEAR && u < CLIP_NEAR) begin
			// at the knee take the limit value
			term = CLIP_LIMIT;
		end else begin
			v = u < 0 ? longint'(-u) : longint'(u);
			e = decay_q30(v);
			den = (64'd1 << 30) - e;
			if (den == 0)
				den = 1;
			term = u > 0 ? longint'((v << 30) / den) : longint'((v * e) / den);
		end
		return clamp_word(longint'(CLIP_BIAS) + term);
	endfunction

	// advance the predictor by one sample and return the expected output
	function automatic logic signed [SBITS-1:0] process_sample(logic signed [SBITS-1:0] x);
		longint acc, fir, hpf, xg, clip, lpf, num, w, wc2, dw, a0, a1, a2, o;
		int unsigned idx;
		acc = 0;
		if (write_ptr >= TAPS)
			write_ptr = 0;
		delay_line[write_ptr] = longint'(x);
		write_ptr = (write_ptr + 1 >= TAPS) ? 0 : write_ptr + 1;
		idx = write_ptr;
		for (int n = 0; n < TAPS; n++) begin
			idx = (idx == 0) ? TAPS - 1 : idx - 1;
			acc += fir_weight(n) * (delay_line[idx] * (64'sd1 <<< (28 - SBITS)));
		end
		fir = clamp_word(round_shift(acc, 15));

		w = longint'(hp_w_reg);
		num = (fir - hp_x_prev) * 131072 + (131072 - w) * hp_y_prev;
		hpf = clamp_word(num / (131072 + w));
		hp_x_prev = fir;
		hp_y_prev = hpf;

		xg = clamp_word(round_shift(longint'(gain_reg) * hpf, 16));
		clip = soft_clip(xg);

		w = longint'(lp_w_reg);
		wc2 = round_shift(w * w, 16);
		dw = round_shift(longint'(lp_damp_reg) * w, 16);
		a1 = 2 * (wc2 - 262144);
		a2 = 262144 - 4 * dw + wc2;
		a0 = 262144 + 4 * dw + wc2;
		num = wc2 * (clip + 2 * lp_x1 + lp_x2) - a1 * lp_y1 - a2 * lp_y2;
		lpf = clamp_word(num / a0);
		lp_x2 = lp_x1;
		lp_x1 = clip;
		lp_y2 = lp_y1;
		lp_y1 = lpf;

		o = clamp(lpf, -(64'sd1 <<< 27), 64'sd1 <<< 27);
		o = round_shift(o, 28 - SBITS);
		o = clamp(o, -(64'sd1 <<< (SBITS - 1)), (64'sd1 <<< (SBITS - 1)) - 1);
		return o[SBITS-1:0];
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 95)
			return $urandom_range(1, 4);
		return $urandom_range(20, 300);
	endfunction

	// drive samples from the pending queue
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_samples.size() > 0) begin
				in_valid <= 1'b1;
				sample_in <= pending_samples.pop_front();
				send_gap <= pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// random backpressure on the result side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			stall_left <= pick_gap();
		end
	end

	// check results first, then predict for the sample taken this edge
	always @(posedge clk) begin
		logic signed [SBITS-1:0] want;
		if (arst_n && out_valid && out_ready) begin
			samples_out++;
			if (expected_samples.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %0d at %0t", sample_out, $realtime);
			end else begin
				want = expected_samples.pop_front();
				if (sample_out !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("sample_out mismatch: expected %0d got %0d at %0t",
							want, sample_out, $realtime);
				end
			end
		end
		if (arst_n && in_valid && in_ready) begin
			samples_in++;
			expected_samples.push_back(process_sample(sample_in));
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_PRE_GAIN: gain_reg = data & 24'hFF_FFFF;
			CFG_HPF_WCT: hp_w_reg = data & 24'h03_FFFF;
			CFG_LPF_WCT: lp_w_reg = data & 24'h03_FFFF;
			CFG_LPF_DAMP: lp_damp_reg = data & 24'h01_FFFF;
			default: ;
		endcase
	endtask

	task automatic set_chain(int gain, int hpw, int lpw, int damp);
		write_reg(CFG_PRE_GAIN, CFG_W'(gain));
		write_reg(CFG_HPF_WCT, CFG_W'(hpw));
		write_reg(CFG_LPF_WCT, CFG_W'(lpw));
		write_reg(CFG_LPF_DAMP, CFG_W'(damp));
		setting_count++;
	endtask

	// hold off until every transfer is done, then let the core settle
	task automatic drain();
		while (pending_samples.size() > 0 || in_valid || expected_samples.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic queue_random(int count);
		int style, amp;
		logic signed [SBITS-1:0] v;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0)
				style = $urandom_range(3);
			case (style)
				0: v = SBITS'($urandom);
				1: begin
					amp = $urandom_range(1, 2000);
					v = SBITS'(int'($urandom_range(2 * amp)) - amp);
				end
				2: v = ((i / $urandom_range(2, 6)) % 2) ? 16'sh7fff : 16'sh8000;
				default: v = (i % 8 < 4) ? SBITS'(16'sh4000 + $urandom_range(255))
					: -16'sh4000;
			endcase
			pending_samples.push_back(v);
		end
	endtask

	initial begin
		gain_reg = 655360;
		hp_w_reg = 858;
		lp_w_reg = 42893;
		lp_damp_reg = 46341;
		write_ptr = 0;
		hp_x_prev = 0; hp_y_prev = 0;
		lp_x1 = 0; lp_x2 = 0; lp_y1 = 0; lp_y2 = 0;
		foreach (delay_line[i]) delay_line[i] = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, impulse, alternating full scale, at reset settings
		pending_samples.push_back(16'sd0);
		pending_samples.push_back(16'sh7fff);
		pending_samples.push_back(16'sh8000);
		pending_samples.push_back(-16'sd1);
		pending_samples.push_back(16'sd1);
		for (int i = 0; i < 8; i++) pending_samples.push_back(16'sd0);
		for (int i = 0; i < 10; i++)
			pending_samples.push_back(i % 2 ? 16'sh8000 : 16'sh7fff);
		drain();

		// out-of-range data is masked; a spare index is ignored
		write_reg(CFG_SPARE_IDX, 24'hFF_FFFF);
		set_chain(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
		queue_random(200);
		drain();

		set_chain(0, 0, 0, 0);
		queue_random(150);
		drain();

		set_chain(16777215, 205887, 205887, 131071);
		queue_random(250);
		drain();

		set_chain(65536, 0, 205887, 0);
		queue_random(200);
		drain();

		set_chain(655360, 858, 42893, 46341);
		queue_random(300);
		drain();

		for (int p = 0; p < 3; p++) begin
			set_chain(int'($urandom_range(16777215)), int'($urandom_range(205887)),
				int'($urandom_range(205887)), int'($urandom_range(131071)));
			queue_random(175);
			drain();
		end

		$display("%0d samples sent, %0d results checked over %0d register settings",
			samples_in, samples_out, setting_count);
		if (mismatches == 0 && expected_samples.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches,
				expected_samples.size());
			$display("FAILED: results differ");
		end
		$finish;
	end

	// watchdog
	initial begin
		#100ms;
		$display("timeout with %0d results outstanding", expected_samples.size());
		$display("FAILED: results differ");
		$finish;
	end

endmodule
